/* sv/cbc_pkg.sv */
`timescale 1ns / 1ps

package cbc_pkg;

    localparam int ROM_BANK_COUNT = 128;
    localparam int RAM_BANK_COUNT = 4;

    localparam int ROM_MOD_SHIFT = 14;
    localparam int ROM_MOD_MUL   = (1 << ROM_MOD_SHIFT) / ROM_BANK_COUNT;

    localparam logic [15:0] ROM_SWITCH_BASE = 16'h4000;
    localparam logic [15:0] RAM_WINDOW_BASE = 16'hA000;
    localparam logic [15:0] RAM_WINDOW_END  = 16'hC000;
    localparam logic [15:0] REG_SPACE_END   = 16'h8000;
    localparam logic [15:0] ROM_LOW_BASE    = 16'h2000;
    localparam logic [15:0] MODE_BASE       = 16'h6000;

    localparam logic [3:0] RAM_ENABLE_CODE  = 4'hA;
    localparam logic [3:0] RAM_DISABLE_CODE = 4'h0;

    localparam logic [2:0] CFG_KIND_ADDR = 3'd0;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_MBC1 = 2'd1,
        KIND_MBC2 = 2'd2,
        KIND_RSVD = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        TGT_ROM   = 2'd0,
        TGT_RAM   = 2'd1,
        TGT_OTHER = 2'd2,
        TGT_REG   = 2'd3
    } target_t;

    typedef enum logic {
        ACT_READ  = 1'b0,
        ACT_WRITE = 1'b1
    } action_t;

    typedef struct packed {
        logic        action;
        logic [15:0] bus_address;
        logic [7:0]  write_byte;
    } access_t;

    typedef struct packed {
        logic [1:0]  target;
        logic [20:0] mapped_offset;
        logic        access_allowed;
    } result_t;

    function automatic logic [6:0] fix_zero_bank(input logic [6:0] b);
        return (b == 7'd0) ? 7'd1 : b;
    endfunction

    // Reduction by a constant bank count through a reciprocal multiply and one correction.
    function automatic logic [6:0] rom_bank_mod(input logic [6:0] b);
        logic [20:0] prod;
        logic [6:0]  q;
        logic [13:0] qd;
        logic [7:0]  r;
        prod = 21'(b) * 21'(ROM_MOD_MUL);
        q    = prod[20:14];
        qd   = 14'(q) * 14'(ROM_BANK_COUNT);
        r    = {1'b0, b} - {1'b0, qd[6:0]};
        if (r >= 8'(ROM_BANK_COUNT))
        begin
            r = r - 8'(ROM_BANK_COUNT);
        end
        return r[6:0];
    endfunction

    function automatic logic [1:0] ram_bank_mod(input logic [1:0] b);
        logic [2:0] r;
        r = {1'b0, b};
        for (int i = 0; i < 3; i++)
        begin
            if (r >= 3'(RAM_BANK_COUNT))
            begin
                r = r - 3'(RAM_BANK_COUNT);
            end
        end
        return r[1:0];
    endfunction

endpackage

/* sv/cartridge_bank_controller.sv */
`timescale 1ns / 1ps

// Cartridge bank controller for MBC1 and MBC2 style cartridges.
// Each transfer on the access channel is one CPU bus access (read or write,
// address, data byte). Each produces exactly one transfer on the result
// channel: where the access lands, the offset into cartridge ROM or external
// RAM, and whether the access proceeds. Writes below 0x8000 update the bank
// registers in the order the accesses arrive.
// The controller kind is set through the APB port at byte address 0; the user
// must change it only while no access is in flight (the block does not enforce it).
// The access waits in the input register while the translation and register
// update logic feeds the result register, which presents the result. One access
// per cycle is sustained while the receiver keeps result_ready high.
// Reset clears the controller kind to none, the ROM bank to 1, the RAM bank
// to 0, RAM to disabled and selects ROM banking mode; both stages empty.
// When the receiver stalls, the result register holds, the input register
// fills behind it, and access_ready drops until the result is taken.
module cartridge_bank_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             access_valid,
    output logic             access_ready,
    input  cbc_pkg::access_t access,
    output logic             result_valid,
    input  logic             result_ready,
    output cbc_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import cbc_pkg::*;

    logic       s1_valid_reg;
    access_t    s1_item_reg;
    logic       out_valid_reg;
    result_t    out_item_reg;
    kind_t      kind_reg;
    logic [6:0] rom_bank_reg;
    logic [6:0] rom_bank_next;
    logic [1:0] ram_bank_reg;
    logic [1:0] ram_bank_next;
    logic       ram_enabled_reg;
    logic       ram_enabled_next;
    logic       rom_banking_mode_reg;
    logic       rom_banking_mode_next;

    logic       s1_advance;
    logic       s1_fire;
    logic       cfg_write;
    result_t    res;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        is_mbc1;
    logic        is_mbc2;

    assign pready       = 1'b1;
    assign cfg_write    = psel && penable && pwrite && pready;
    assign prdata       = (paddr == CFG_KIND_ADDR) ? {30'd0, kind_reg} : 32'd0;

    assign s1_advance   = !out_valid_reg || result_ready;
    assign s1_fire      = s1_valid_reg && s1_advance;
    assign access_ready = !s1_valid_reg || s1_advance;
    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    assign addr    = s1_item_reg.bus_address;
    assign data    = s1_item_reg.write_byte;
    assign is_mbc1 = (kind_reg == KIND_MBC1);
    assign is_mbc2 = (kind_reg == KIND_MBC2);

    always_comb
    begin
        logic [6:0] rom_upd;
        logic [1:0] ram_upd;
        logic       en_upd;
        logic       mode_upd;
        rom_upd  = rom_bank_reg;
        ram_upd  = ram_bank_reg;
        en_upd   = ram_enabled_reg;
        mode_upd = rom_banking_mode_reg;
        res.target         = TGT_OTHER;
        res.mapped_offset  = {5'd0, addr};
        res.access_allowed = 1'b1;

        if (s1_item_reg.action == ACT_WRITE && addr < REG_SPACE_END)
        begin
            res.target         = TGT_REG;
            res.access_allowed = 1'b0;
            if (addr < ROM_LOW_BASE)
            begin
                if ((is_mbc1 || is_mbc2) && !(is_mbc2 && addr[8]))
                begin
                    res.access_allowed = 1'b1;
                    if (data[3:0] == RAM_ENABLE_CODE)
                    begin
                        en_upd = 1'b1;
                    end
                    else if (data[3:0] == RAM_DISABLE_CODE)
                    begin
                        en_upd = 1'b0;
                    end
                end
            end
            else if (addr < ROM_SWITCH_BASE)
            begin
                if (is_mbc2)
                begin
                    res.access_allowed = 1'b1;
                    rom_upd = fix_zero_bank({3'd0, data[3:0]});
                end
                else if (is_mbc1)
                begin
                    res.access_allowed = 1'b1;
                    rom_upd = fix_zero_bank({rom_bank_reg[6:5], data[4:0]});
                end
            end
            else if (is_mbc1)
            begin
                res.access_allowed = 1'b1;
                if (addr < MODE_BASE)
                begin
                    if (rom_banking_mode_reg)
                    begin
                        rom_upd = fix_zero_bank({data[1:0], rom_bank_reg[4:0]});
                    end
                    else
                    begin
                        ram_upd = data[1:0];
                    end
                end
                else
                begin
                    mode_upd = !data[0];
                    if (!data[0])
                    begin
                        ram_upd = 2'd0;
                    end
                end
            end
        end
        else if (addr < ROM_SWITCH_BASE)
        begin
            res.target = TGT_ROM;
        end
        else if (addr < REG_SPACE_END)
        begin
            res.target        = TGT_ROM;
            res.mapped_offset = {rom_bank_mod(rom_bank_reg), addr[13:0]};
        end
        else if (addr >= RAM_WINDOW_BASE && addr < RAM_WINDOW_END)
        begin
            res.target        = TGT_RAM;
            res.mapped_offset = {6'd0, ram_bank_mod(ram_bank_reg), addr[12:0]};
            if (s1_item_reg.action == ACT_WRITE)
            begin
                res.access_allowed = ram_enabled_reg;
            end
        end

        rom_bank_next         = s1_fire ? rom_upd  : rom_bank_reg;
        ram_bank_next         = s1_fire ? ram_upd  : ram_bank_reg;
        ram_enabled_next      = s1_fire ? en_upd   : ram_enabled_reg;
        rom_banking_mode_next = s1_fire ? mode_upd : rom_banking_mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            kind_reg             <= KIND_NONE;
            rom_bank_reg         <= 7'd1;
            ram_bank_reg         <= 2'd0;
            ram_enabled_reg      <= 1'b0;
            rom_banking_mode_reg <= 1'b1;
        end
        else
        begin
            if (access_ready)
            begin
                s1_valid_reg <= access_valid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (cfg_write && paddr == CFG_KIND_ADDR)
            begin
                kind_reg <= kind_t'(pwdata[1:0]);
            end
            rom_bank_reg         <= rom_bank_next;
            ram_bank_reg         <= ram_bank_next;
            ram_enabled_reg      <= ram_enabled_next;
            rom_banking_mode_reg <= rom_banking_mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (access_ready && access_valid)
        begin
            s1_item_reg <= access;
        end
        if (s1_fire)
        begin
            out_item_reg <= res;
        end
    end

    a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rom_bank_reg != 7'd0)
        else $error("ROM bank register holds zero.");

    a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(rom_bank_reg) && $stable(ram_bank_reg)
                     && $stable(ram_enabled_reg) && $stable(rom_banking_mode_reg))
        else $error("Bank state changed without a completed access.");

    a_rom_mode_ram_bank: assert property (@(posedge clk) disable iff (!rst_n)
        rom_banking_mode_reg |-> ram_bank_reg == 2'd0)
        else $error("RAM bank nonzero in ROM banking mode.");

    a_reg_write_offset: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.target == TGT_REG |-> result.mapped_offset[20:15] == 6'd0)
        else $error("Register write result carries an address above the register space.");

endmodule

/* tb/tb_cartridge_bank_controller.sv */
`timescale 1ns / 1ps

module tb_cartridge_bank_controller;

    import cbc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 170;
    localparam int MAX_PRINTED  = 40;

    logic        clk;
    logic        rst_n;
    logic        access_valid;
    logic        access_ready;
    access_t     access;
    logic        result_valid;
    logic        result_ready;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    access_t     pending_accesses[$];
    result_t     expected_results[$];
    result_t     oldest_expected;

    kind_t       kind_sel;
    logic [6:0]  bank_rom;
    logic [1:0]  bank_ram;
    logic        ram_on;
    logic        rom_mode;

    logic        access_done;
    logic        result_done;
    int          access_gap;
    int          result_stall;
    bit          idle_access;
    bit          idle_result;
    int          error_count;
    int          cycle_count;

    cartridge_bank_controller u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .access_valid (access_valid),
        .access_ready (access_ready),
        .access       (access),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (error_count < MAX_PRINTED)
        begin
            $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        end
        error_count++;
    endtask

    function automatic int draw_gap(input bit enabled);
        if (!enabled)
        begin
            return 0;
        end
        if ($urandom_range(0, 2) == 0)
        begin
            return $urandom_range(0, 17);
        end
        return 0;
    endfunction

    function automatic logic [6:0] bank_or_one(input logic [6:0] b);
        return (b == 7'd0) ? 7'd1 : b;
    endfunction

    // Applies a write below 0x8000 to the bank registers and tells whether the
    // fitted controller takes it.
    function automatic logic apply_bank_write(input logic [15:0] addr, input logic [7:0] data);
        logic is_mbc1;
        logic is_mbc2;
        is_mbc1 = (kind_sel == KIND_MBC1);
        is_mbc2 = (kind_sel == KIND_MBC2);
        if (addr < ROM_LOW_BASE)
        begin
            if (!is_mbc1 && !is_mbc2)
            begin
                return 1'b0;
            end
            if (is_mbc2 && addr[8])
            begin
                return 1'b0;
            end
            if (data[3:0] == RAM_ENABLE_CODE)
            begin
                ram_on = 1'b1;
            end
            else if (data[3:0] == RAM_DISABLE_CODE)
            begin
                ram_on = 1'b0;
            end
            return 1'b1;
        end
        if (addr < ROM_SWITCH_BASE)
        begin
            if (is_mbc2)
            begin
                bank_rom = bank_or_one({3'b000, data[3:0]});
                return 1'b1;
            end
            if (is_mbc1)
            begin
                bank_rom = bank_or_one({bank_rom[6:5], data[4:0]});
                return 1'b1;
            end
            return 1'b0;
        end
        if (!is_mbc1)
        begin
            return 1'b0;
        end
        if (addr < MODE_BASE)
        begin
            if (rom_mode)
            begin
                bank_rom = bank_or_one({data[1:0], bank_rom[4:0]});
            end
            else
            begin
                bank_ram = data[1:0];
            end
            return 1'b1;
        end
        rom_mode = ~data[0];
        if (rom_mode)
        begin
            bank_ram = 2'd0;
        end
        return 1'b1;
    endfunction

    function automatic result_t map_access(input access_t a);
        result_t r;
        r.target         = TGT_OTHER;
        r.mapped_offset  = 21'(a.bus_address);
        r.access_allowed = 1'b1;
        if (a.action == ACT_WRITE && a.bus_address < REG_SPACE_END)
        begin
            r.target         = TGT_REG;
            r.access_allowed = apply_bank_write(a.bus_address, a.write_byte);
        end
        else if (a.bus_address < ROM_SWITCH_BASE)
        begin
            r.target = TGT_ROM;
        end
        else if (a.bus_address < REG_SPACE_END)
        begin
            r.target        = TGT_ROM;
            r.mapped_offset = 21'(int'(bank_rom) % ROM_BANK_COUNT) * 21'h4000
                            + 21'(a.bus_address - ROM_SWITCH_BASE);
        end
        else if (a.bus_address >= RAM_WINDOW_BASE && a.bus_address < RAM_WINDOW_END)
        begin
            r.target         = TGT_RAM;
            r.mapped_offset  = 21'(int'(bank_ram) % RAM_BANK_COUNT) * 21'h2000
                             + 21'(a.bus_address - RAM_WINDOW_BASE);
            r.access_allowed = (a.action == ACT_WRITE) ? ram_on : 1'b1;
        end
        return r;
    endfunction

    function automatic access_t make_access(input logic act, input logic [15:0] addr,
                                            input logic [7:0] data);
        access_t a;
        a.action      = act;
        a.bus_address = addr;
        a.write_byte  = data;
        return a;
    endfunction

    // Mostly well-formed bank register writes and window accesses, with some
    // fully random transfers mixed in.
    function automatic access_t random_access();
        access_t a;
        a = make_access(1'($urandom_range(0, 1)), 16'($urandom_range(0, 16'hFFFF)),
                        8'($urandom_range(0, 8'hFF)));
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                a.action      = ACT_WRITE;
                a.bus_address = 16'($urandom_range(0, 16'h7FFF));
                if ($urandom_range(0, 1) == 0)
                begin
                    a.write_byte[3:0] = ($urandom_range(0, 1) == 0) ? RAM_ENABLE_CODE
                                                                    : RAM_DISABLE_CODE;
                end
            end
            3, 4:
            begin
                a.action      = ACT_READ;
                a.bus_address = 16'($urandom_range(16'h4000, 16'h7FFF));
            end
            5, 6:
            begin
                a.bus_address = 16'($urandom_range(16'hA000, 16'hBFFF));
            end
            7:
            begin
                a.action      = ACT_READ;
                a.bus_address = 16'($urandom_range(0, 16'h3FFF));
            end
            default:
            begin
            end
        endcase
        return a;
    endfunction

    task automatic wait_drained();
        while (pending_accesses.size() != 0 || access_valid || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic set_controller_kind(input kind_t k);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= CFG_KIND_ADDR;
        pwdata  <= 32'(k);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        kind_sel = k;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata != 32'(k))
        begin
            report_mismatch("controller kind readback", prdata, 32'(k));
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (rst_n && (!access_valid || access_done))
        begin
            if (access_gap > 0)
            begin
                access_valid <= 1'b0;
                access_gap   <= access_gap - 1;
            end
            else if (pending_accesses.size() != 0)
            begin
                access       <= pending_accesses.pop_front();
                access_valid <= 1'b1;
                access_gap   <= draw_gap(idle_access);
            end
            else
            begin
                access_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : result_sink
        int stall;
        if (rst_n)
        begin
            stall = result_done ? draw_gap(idle_result) : result_stall;
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                result_stall <= stall - 1;
            end
            else
            begin
                result_ready <= 1'b1;
                result_stall <= 0;
            end
        end
    end

    always @(posedge clk)
    begin
        access_done <= access_valid && access_ready;
        result_done <= result_valid && result_ready;
        if (rst_n && access_valid && access_ready)
        begin
            expected_results.push_back(map_access(access));
        end
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result transfer with none expected", 32'(result), 32'd0);
            end
            else
            begin
                oldest_expected = expected_results.pop_front();
                if (result.target != oldest_expected.target)
                begin
                    report_mismatch("target", 32'(result.target),
                                    32'(oldest_expected.target));
                end
                if (result.mapped_offset != oldest_expected.mapped_offset)
                begin
                    report_mismatch("mapped_offset", 32'(result.mapped_offset),
                                    32'(oldest_expected.mapped_offset));
                end
                if (result.access_allowed != oldest_expected.access_allowed)
                begin
                    report_mismatch("access_allowed", 32'(result.access_allowed),
                                    32'(oldest_expected.access_allowed));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : stimulus
        kind_t phase_kinds[7];
        phase_kinds = '{KIND_MBC1, KIND_MBC2, KIND_NONE, KIND_RSVD,
                        KIND_MBC1, KIND_MBC2, KIND_MBC1};
        rst_n        = 1'b0;
        access_valid = 1'b0;
        access       = '0;
        result_ready = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        access_done  = 1'b0;
        result_done  = 1'b0;
        access_gap   = 0;
        result_stall = 0;
        idle_access  = 1'b1;
        idle_result  = 1'b1;
        error_count  = 0;
        cycle_count  = 0;
        kind_sel     = KIND_NONE;
        bank_rom     = 7'd1;
        bank_ram     = 2'd0;
        ram_on       = 1'b0;
        rom_mode     = 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // With no controller fitted, register writes are refused.
        pending_accesses.push_back(make_access(ACT_WRITE, 16'h0000, 8'h0A));
        pending_accesses.push_back(make_access(ACT_WRITE, 16'h2000, 8'h05));
        pending_accesses.push_back(make_access(ACT_READ,  16'h4000, 8'h00));
        wait_drained();

        set_controller_kind(KIND_MBC1);
        pending_accesses.push_back(make_access(ACT_READ,  16'h0000, 8'hFF));
        pending_accesses.push_back(make_access(ACT_READ,  16'h7FFF, 8'h00));
        pending_accesses.push_back(make_access(ACT_WRITE, 16'h0000, 8'h0A));
        pending_accesses.push_back(make_access(ACT_WRITE, 16'hA000, 8'hFF));
        pending_accesses.push_back(make_access(ACT_WRITE, 16'h3FFF, 8'h1F));
        pending_accesses.push_back(make_access(ACT_WRITE, 16'h4000, 8'h03));
        pending_accesses.push_back(make_access(ACT_READ,  16'h7FFF, 8'h00));
        // Low bits zero with high bits set keeps the bank; all zero becomes bank 1.
        pending_accesses.push_back(make_access(ACT_WRITE, 16'h2000, 8'h00));
        pending_accesses.push_back(make_access(ACT_WRITE, 16'h5FFF, 8'h00));
        pending_accesses.push_back(make_access(ACT_WRITE, 16'h6000, 8'h01));
        pending_accesses.push_back(make_access(ACT_WRITE, 16'h4000, 8'h03));
        pending_accesses.push_back(make_access(ACT_READ,  16'hBFFF, 8'h00));
        pending_accesses.push_back(make_access(ACT_WRITE, 16'h1FFF, 8'h05));
        pending_accesses.push_back(make_access(ACT_WRITE, 16'h0000, 8'hF0));
        pending_accesses.push_back(make_access(ACT_WRITE, 16'hBFFF, 8'h00));
        pending_accesses.push_back(make_access(ACT_WRITE, 16'h7FFF, 8'hFE));
        pending_accesses.push_back(make_access(ACT_READ,  16'hA000, 8'h00));
        pending_accesses.push_back(make_access(ACT_WRITE, 16'hFFFF, 8'hFF));
        pending_accesses.push_back(make_access(ACT_READ,  16'h8000, 8'h00));
        wait_drained();

        // On MBC2 the enable register ignores writes with address bit 8 set.
        set_controller_kind(KIND_MBC2);
        pending_accesses.push_back(make_access(ACT_WRITE, 16'h0100, 8'h0A));
        pending_accesses.push_back(make_access(ACT_WRITE, 16'h2000, 8'hF0));
        pending_accesses.push_back(make_access(ACT_WRITE, 16'h3000, 8'hFF));
        pending_accesses.push_back(make_access(ACT_WRITE, 16'h4000, 8'h01));
        pending_accesses.push_back(make_access(ACT_READ,  16'h4000, 8'h00));
        wait_drained();

        set_controller_kind(KIND_RSVD);
        pending_accesses.push_back(make_access(ACT_WRITE, 16'h0000, 8'h0A));
        pending_accesses.push_back(make_access(ACT_WRITE, 16'h2000, 8'h02));
        wait_drained();

        foreach (phase_kinds[p])
        begin
            set_controller_kind(phase_kinds[p]);
            idle_access = (p != 4) && ($urandom_range(0, 3) != 0);
            idle_result = (p != 4) && ($urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                pending_accesses.push_back(random_access());
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
